// ===== rtl/rect_pkg.sv =====
// Shared types and constants for the RECTANGLE block decryption core.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package rect_pkg;

    // Default number of decryption rounds; the key store holds one more entry.
    localparam int DEFAULT_ROUNDS = 25;

    // Fixed field widths of the command interface.
    localparam int SLOT_W  = 5;
    localparam int BLOCK_W = 64;
    localparam int ROW_W   = 16;

    // Right-rotation amounts for rows 1, 2 and 3.
    localparam int ROT_ROW1 = 1;
    localparam int ROT_ROW2 = 12;
    localparam int ROT_ROW3 = 13;

    // Opcode values.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_en;    // write data_word into the key store
        logic start_dec;  // capture the ciphertext
        logic round_en;   // apply one inverse round with the fetched key
        logic final_en;   // final key XOR into the output register
    } rect_cmd_t;

endpackage

// ===== rtl/rect_ctrl.sv =====
// Controller for the RECTANGLE decryption core: beat acceptance, round
// sequencing and key store read addressing. Depends on rect_pkg.
`timescale 1ns / 1ps

module rect_ctrl
    import rect_pkg::*;
#(
    parameter int ROUNDS = DEFAULT_ROUNDS,
    parameter int KW     = $clog2(ROUNDS + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          opcode,
    output logic          busy,
    output logic          done,
    output rect_cmd_t     cmd,
    output logic [KW-1:0] rd_addr
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINAL
    } state_t;

    state_t        state_reg, state_next;
    logic [KW-1:0] ctr_reg, ctr_next;
    logic          done_reg, done_next;
    logic          accept;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign accept = start && (state_reg == ST_IDLE);

    // Next-state, counter and command decode.
    always_comb
    begin
        state_next    = state_reg;
        ctr_next      = ctr_reg;
        done_next     = 1'b0;
        cmd.load_en   = 1'b0;
        cmd.start_dec = 1'b0;
        cmd.round_en  = 1'b0;
        cmd.final_en  = 1'b0;
        rd_addr       = ctr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = KW'(ROUNDS);
                if (accept)
                begin
                    if (opcode == OP_DECRYPT)
                    begin
                        cmd.start_dec = 1'b1;
                        ctr_next      = KW'(ROUNDS);
                        state_next    = ST_RUN;
                    end
                    else
                    begin
                        cmd.load_en = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                // The key for this round was fetched last cycle; fetch the next.
                cmd.round_en = 1'b1;
                rd_addr      = ctr_reg - KW'(1);
                ctr_next     = ctr_reg - KW'(1);
                if (ctr_reg == KW'(1))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                cmd.final_en = 1'b1;
                done_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ctr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ===== rtl/rect_dp.sv =====
// Datapath for the RECTANGLE decryption core: round key store, state
// register, one inverse round per cycle and the output register. Depends on rect_pkg.
`timescale 1ns / 1ps

module rect_dp
    import rect_pkg::*;
#(
    parameter int ROUNDS = DEFAULT_ROUNDS,
    parameter int KW     = $clog2(ROUNDS + 1)
)
(
    input  logic               clk,
    input  rect_cmd_t          cmd,
    input  logic [KW-1:0]      rd_addr,
    input  logic [SLOT_W-1:0]  key_slot,
    input  logic [BLOCK_W-1:0] data_word,
    output logic [BLOCK_W-1:0] plain_block
);

    localparam int DEPTH = ROUNDS + 1;

    logic [BLOCK_W-1:0] key_mem [DEPTH];
    logic [BLOCK_W-1:0] key_q;
    logic [BLOCK_W-1:0] blk_reg, blk_next;
    logic [BLOCK_W-1:0] plain_reg;
    logic [BLOCK_W-1:0] mixed;
    logic [ROW_W-1:0]   r0, r1, r2, r3;
    logic [ROW_W-1:0]   a1, d1, d2, b1, c1, b2, b3, d3, d4, d5, a2, a3;

    // Key store: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.load_en && (key_slot <= SLOT_W'(ROUNDS)))
        begin
            key_mem[key_slot[KW-1:0]] <= data_word;
        end
        key_q <= key_mem[rd_addr];
    end

    // Key XOR, row rotations and the bitsliced inverse S-box.
    always_comb
    begin
        mixed = blk_reg ^ key_q;
        r0 = mixed[ROW_W-1:0];
        r1 = (mixed[2*ROW_W-1:ROW_W] >> ROT_ROW1)
           | (mixed[2*ROW_W-1:ROW_W] << (ROW_W - ROT_ROW1));
        r2 = (mixed[3*ROW_W-1:2*ROW_W] >> ROT_ROW2)
           | (mixed[3*ROW_W-1:2*ROW_W] << (ROW_W - ROT_ROW2));
        r3 = (mixed[4*ROW_W-1:3*ROW_W] >> ROT_ROW3)
           | (mixed[4*ROW_W-1:3*ROW_W] << (ROW_W - ROT_ROW3));
        a1 = (r0 & r2) ^ r3;
        d1 = r3 | r0;
        d2 = d1 ^ r2;
        b1 = r1 ^ d2;
        c1 = b1;
        b2 = b1 ^ r0;
        b3 = b2 ^ a1;
        d3 = ~d2;
        d4 = d3 | b3;
        d5 = d4 ^ a1;
        a2 = a1 & b3;
        a3 = a2 ^ d3;
        blk_next = {d5, c1, b3, a3};
    end

    // State and output registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start_dec)
        begin
            blk_reg <= data_word;
        end
        else if (cmd.round_en)
        begin
            blk_reg <= blk_next;
        end
        if (cmd.final_en)
        begin
            plain_reg <= blk_reg ^ key_q;
        end
    end

    assign plain_block = plain_reg;

endmodule

// ===== rtl/rectangle_block_decrypt.sv =====
// Top level of the RECTANGLE-64 block decryption core.
// Instantiates rect_ctrl and rect_dp; depends on rect_pkg.
`timescale 1ns / 1ps

// Usage:
// A command beat is taken at a rising edge where start is high and busy is
// low. With opcode OP_LOAD the beat writes data_word into round key slot
// key_slot (slots above ROUNDS are ignored); it gives no result and the
// block is ready again in the next cycle. With opcode OP_DECRYPT the beat
// carries a ciphertext block as four 16-bit rows, row j in bits 16j+15..16j.
// The controller then holds busy high while the datapath runs one inverse
// round per cycle, fetching each round key from the key store in the cycle
// before its round. The plaintext appears on plain_block with done high for
// exactly one cycle. A single shared round unit serves every round, so no
// new beat is taken while a block is being decrypted. All round keys
// 0..ROUNDS must be loaded before a decryption. Reset clears the controller
// only; the key store keeps no reset value. The receiver cannot hold
// results off: done is a strobe.

module rectangle_block_decrypt
    import rect_pkg::*;
#(
    parameter int ROUNDS = DEFAULT_ROUNDS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [SLOT_W-1:0]  key_slot,
    input  logic [BLOCK_W-1:0] data_word,
    output logic               done,
    output logic [BLOCK_W-1:0] plain_block
);

    localparam int KW = $clog2(ROUNDS + 1);

    rect_cmd_t     cmd;
    logic [KW-1:0] rd_addr;

    rect_ctrl #(
        .ROUNDS (ROUNDS),
        .KW     (KW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .opcode  (opcode),
        .busy    (busy),
        .done    (done),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    rect_dp #(
        .ROUNDS (ROUNDS),
        .KW     (KW)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .key_slot    (key_slot),
        .data_word   (data_word),
        .plain_block (plain_block)
    );

endmodule
